// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the masked column raster block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check that is switched off while reset is high.
`define CMR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("masked column raster check failed");
// Clocked check that also holds through reset.
`define CMR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("masked column raster check failed");
`else
`define CMR_ASSERT(label, clk, rst, prop)
`define CMR_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- rtl/cmr_pkg.sv -----
// Types, constants and the raster function of the masked column raster block.
package cmr_pkg;

   // Default sizes of the pattern store and of the tallest column.
   localparam int PATTERN_DEPTH_DEF = 16;
   localparam int MAX_HEIGHT_DEF    = 1024;

   // Field widths fixed by the interface.
   localparam int SLOT_W   = 4;
   localparam int SLOT_CNT = 2 ** SLOT_W;
   localparam int COLH_W   = 11;
   localparam int COLH_MAX = 2 ** COLH_W - 1;
   // Wide enough to compare pattern heights against store depths up to 511.
   localparam int HGT_W    = 9;

   // Configuration port.
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   // Register indexes.
   typedef enum logic [2:0] {
      REG_TRANSFER_MODE  = 3'd0,
      REG_BYTE_MASK      = 3'd1,
      REG_COLUMN_MODE    = 3'd2,
      REG_PATTERN_HEIGHT = 3'd3,
      REG_START_INDEX    = 3'd4,
      REG_DST_ROW_STEP   = 3'd5,
      REG_SRC_ROW_STEP   = 3'd6,
      REG_COLUMN_HEIGHT  = 3'd7
   } reg_index_type;

   // Input word actions.
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_DRAW  = 2'd2;

   // Raster operations in the low two bits of the transfer mode.
   localparam logic [1:0] ROP_COPY = 2'd0;
   localparam logic [1:0] ROP_OR   = 2'd1;
   localparam logic [1:0] ROP_XOR  = 2'd2;
   localparam logic [1:0] ROP_BIC  = 2'd3;

   // Configuration register set.
   typedef struct packed {
      logic [2:0]         transfer_mode;
      logic [7:0]         byte_mask;
      logic               column_mode;
      logic [4:0]         pattern_height;
      logic [3:0]         start_index;
      logic signed [15:0] dst_row_step;
      logic signed [15:0] src_row_step;
      logic [10:0]        column_height;
   } cfg_type;

   // One drawn row on its way from the row stage to the raster stage.
   typedef struct packed {
      logic [7:0]         src_byte;
      logic [7:0]         dst_byte;
      logic signed [31:0] dst_offset;
      logic signed [31:0] src_offset;
      logic               last_row;
   } row_type;

   // Masked raster operation of one source byte into one destination byte.
   function automatic logic [7:0] raster_op(input logic [2:0] mode, input logic [7:0] mask,
                                           input logic [7:0] src, input logic [7:0] dst);
      logic [7:0] s;
      logic [7:0] r;
      s = (mode[2] ? ~src : src) & mask;
      case (mode[1:0])
         ROP_COPY: r = (dst & ~mask) | s;
         ROP_OR:   r = dst | s;
         ROP_XOR:  r = dst ^ s;
         ROP_BIC:  r = dst & ~s;
         default:  r = dst & ~s;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/cmr_csr.sv -----
// Configuration registers of the masked column raster block behind an APB-style port.
module cmr_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [cmr_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [cmr_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [cmr_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready,
   output cmr_pkg::cfg_type           cfg
);

   cmr_pkg::cfg_type       cfg_ff;
   cmr_pkg::cfg_type       cfg_in;
   cmr_pkg::reg_index_type reg_index;
   logic                   write_en;

   assign csr_pready = 1'b1;
   assign reg_index  = cmr_pkg::reg_index_type'(csr_paddr[cmr_pkg::CSR_AW-1:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            cmr_pkg::REG_TRANSFER_MODE:  cfg_in.transfer_mode  = csr_pwdata[2:0];
            cmr_pkg::REG_BYTE_MASK:      cfg_in.byte_mask      = csr_pwdata[7:0];
            cmr_pkg::REG_COLUMN_MODE:    cfg_in.column_mode    = csr_pwdata[0];
            cmr_pkg::REG_PATTERN_HEIGHT: cfg_in.pattern_height = csr_pwdata[4:0];
            cmr_pkg::REG_START_INDEX:    cfg_in.start_index    = csr_pwdata[3:0];
            cmr_pkg::REG_DST_ROW_STEP:   cfg_in.dst_row_step   = $signed(csr_pwdata[15:0]);
            cmr_pkg::REG_SRC_ROW_STEP:   cfg_in.src_row_step   = $signed(csr_pwdata[15:0]);
            cmr_pkg::REG_COLUMN_HEIGHT:  cfg_in.column_height  = csr_pwdata[10:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.transfer_mode  <= 3'd0;
         cfg_ff.byte_mask      <= 8'hFF;
         cfg_ff.column_mode    <= 1'b0;
         cfg_ff.pattern_height <= 5'd8;
         cfg_ff.start_index    <= 4'd0;
         cfg_ff.dst_row_step   <= 16'sd0;
         cfg_ff.src_row_step   <= 16'sd0;
         cfg_ff.column_height  <= 11'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register read mux, zero-extended to the data width.
   always_comb begin
      case (reg_index)
         cmr_pkg::REG_TRANSFER_MODE:  csr_prdata = {29'd0, cfg_ff.transfer_mode};
         cmr_pkg::REG_BYTE_MASK:      csr_prdata = {24'd0, cfg_ff.byte_mask};
         cmr_pkg::REG_COLUMN_MODE:    csr_prdata = {31'd0, cfg_ff.column_mode};
         cmr_pkg::REG_PATTERN_HEIGHT: csr_prdata = {27'd0, cfg_ff.pattern_height};
         cmr_pkg::REG_START_INDEX:    csr_prdata = {28'd0, cfg_ff.start_index};
         cmr_pkg::REG_DST_ROW_STEP:   csr_prdata = {16'd0, cfg_ff.dst_row_step};
         cmr_pkg::REG_SRC_ROW_STEP:   csr_prdata = {16'd0, cfg_ff.src_row_step};
         cmr_pkg::REG_COLUMN_HEIGHT:  csr_prdata = {21'd0, cfg_ff.column_height};
         default:                     csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/cmr_row_ctrl.sv -----
// Row stage: column state, pattern store and the input register of a drawn row.
module cmr_row_ctrl #(
   parameter int PATTERN_DEPTH = cmr_pkg::PATTERN_DEPTH_DEF,
   parameter int MAX_HEIGHT    = cmr_pkg::MAX_HEIGHT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmr_pkg::cfg_type  cfg,
   input  logic              req_accept,
   input  logic [1:0]        req_action,
   input  logic [3:0]        req_pattern_slot,
   input  logic [7:0]        req_src_byte,
   input  logic [7:0]        req_dst_byte,
   input  logic              row_load,
   output logic              row_valid,
   output cmr_pkg::row_type  row
);

   localparam int IDX_W = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
   localparam int HMAX  = (MAX_HEIGHT < cmr_pkg::COLH_MAX) ? MAX_HEIGHT : cmr_pkg::COLH_MAX;
   localparam int ROW_W = $clog2(HMAX + 1);
   localparam int HW    = cmr_pkg::HGT_W;

   // Column state.
   logic [IDX_W-1:0]   pat_idx_ff, pat_idx_in;
   logic [ROW_W-1:0]   row_cnt_ff, row_cnt_in;
   logic [31:0]        dst_acc_ff, dst_acc_in;
   logic [31:0]        src_acc_ff, src_acc_in;

   // Row register and pattern store.
   logic               row_valid_ff, row_valid_in;
   logic [7:0]         src_ff;
   logic [7:0]         dst_ff;
   logic               pat_ff;
   logic signed [31:0] doff_ff;
   logic signed [31:0] soff_ff;
   logic               last_ff;
   logic [7:0]         pat_rd_ff;
   logic [7:0]         pattern_mem_ff [PATTERN_DEPTH];

   logic [IDX_W-1:0]   slot_map [cmr_pkg::SLOT_CNT];
   logic [HW-1:0]      ph_raw;
   logic [HW-1:0]      eff_ph;
   logic [ROW_W-1:0]   eff_ch;
   logic [HW-1:0]      idx_inc;
   logic [IDX_W-1:0]   idx_next;
   logic [HW-1:0]      start_ext;
   logic [IDX_W-1:0]   idx_start;
   logic [ROW_W:0]     row_inc;
   logic               is_draw;
   logic               draw_ok;
   logic               is_load;
   logic               last_row;
   logic [31:0]        dst_step;
   logic [31:0]        src_step;

   // Load slots wrap onto the store depth.
   genvar gs;
   generate
      for (gs = 0; gs < cmr_pkg::SLOT_CNT; gs++) begin : g_slot
         assign slot_map[gs] = IDX_W'(gs % PATTERN_DEPTH);
      end
   endgenerate

   // Effective pattern and column heights.
   always_comb begin
      ph_raw = (cfg.pattern_height == 5'd0) ? HW'(1) : HW'(cfg.pattern_height);
      eff_ph = (ph_raw > HW'(PATTERN_DEPTH)) ? HW'(PATTERN_DEPTH) : ph_raw;
      eff_ch = (cfg.column_height > cmr_pkg::COLH_W'(HMAX)) ?
               ROW_W'(HMAX) : ROW_W'(cfg.column_height);
   end

   // Pattern index stepping and column start.
   always_comb begin
      idx_inc   = HW'(pat_idx_ff) + HW'(1);
      idx_next  = (idx_inc >= eff_ph || idx_inc >= HW'(PATTERN_DEPTH)) ?
                  '0 : IDX_W'(idx_inc);
      start_ext = HW'(cfg.start_index);
      idx_start = (start_ext < eff_ph) ? IDX_W'(start_ext) : '0;
   end

   assign is_load  = req_accept && (req_action == cmr_pkg::ACT_LOAD);
   assign is_draw  = req_accept && (req_action == cmr_pkg::ACT_DRAW);
   assign draw_ok  = is_draw && (row_cnt_ff < eff_ch);
   assign row_inc  = {1'b0, row_cnt_ff} + (ROW_W+1)'(1);
   assign last_row = (row_inc == {1'b0, eff_ch});
   assign dst_step = {{16{cfg.dst_row_step[15]}}, cfg.dst_row_step};
   assign src_step = {{16{cfg.src_row_step[15]}}, cfg.src_row_step};

   // Next column state.
   always_comb begin
      pat_idx_in = pat_idx_ff;
      row_cnt_in = row_cnt_ff;
      dst_acc_in = dst_acc_ff;
      src_acc_in = src_acc_ff;
      if (req_accept && req_action == cmr_pkg::ACT_START) begin
         pat_idx_in = idx_start;
         row_cnt_in = '0;
         dst_acc_in = '0;
         src_acc_in = '0;
      end else if (draw_ok) begin
         row_cnt_in = row_inc[ROW_W-1:0];
         dst_acc_in = dst_acc_ff + dst_step;
         if (cfg.column_mode) begin
            pat_idx_in = idx_next;
         end else begin
            src_acc_in = src_acc_ff + src_step;
         end
      end
   end

   assign row_valid_in = row_load ? draw_ok : row_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_idx_ff   <= '0;
         row_cnt_ff   <= '0;
         dst_acc_ff   <= '0;
         src_acc_ff   <= '0;
         row_valid_ff <= 1'b0;
      end else begin
         pat_idx_ff   <= pat_idx_in;
         row_cnt_ff   <= row_cnt_in;
         dst_acc_ff   <= dst_acc_in;
         src_acc_ff   <= src_acc_in;
         row_valid_ff <= row_valid_in;
      end
   end

   // Row payload, captured when a drawn row enters.
   always_ff @(posedge clock) begin
      if (draw_ok) begin
         src_ff  <= req_src_byte;
         dst_ff  <= req_dst_byte;
         pat_ff  <= cfg.column_mode;
         doff_ff <= $signed(dst_acc_ff);
         soff_ff <= cfg.column_mode ? 32'sd0 : $signed(src_acc_ff);
         last_ff <= last_row;
      end
   end

   // Pattern store: written by loads, read at the pattern index by draws.
   always_ff @(posedge clock) begin
      if (is_load) begin
         pattern_mem_ff[slot_map[req_pattern_slot]] <= req_src_byte;
      end
      if (is_draw) begin
         pat_rd_ff <= pattern_mem_ff[pat_idx_ff];
      end
   end

   assign row_valid       = row_valid_ff;
   assign row.src_byte    = pat_ff ? pat_rd_ff : src_ff;
   assign row.dst_byte    = dst_ff;
   assign row.dst_offset  = doff_ff;
   assign row.src_offset  = soff_ff;
   assign row.last_row    = last_ff;

endmodule

// ----- rtl/cmr_rop_stage.sv -----
// Raster stage: masked raster operation into the result register.
module cmr_rop_stage (
   input  logic               clock,
   input  logic               reset,
   input  cmr_pkg::cfg_type   cfg,
   input  logic               row_valid,
   input  cmr_pkg::row_type   row,
   input  logic               rsp_stall,
   output logic               out_free,
   output logic               rsp_valid,
   output logic [7:0]         rsp_new_dst_byte,
   output logic signed [31:0] rsp_dst_offset,
   output logic signed [31:0] rsp_src_offset,
   output logic               rsp_last_row
);

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         new_dst_ff;
   logic signed [31:0] dst_off_ff;
   logic signed [31:0] src_off_ff;
   logic               last_ff;
   logic [7:0]         new_dst;

   // The result register takes a new word when it is empty or being taken.
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = out_free ? row_valid : rsp_valid_ff;
   assign new_dst      = cmr_pkg::raster_op(cfg.transfer_mode, cfg.byte_mask,
                                            row.src_byte, row.dst_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (out_free && row_valid) begin
         new_dst_ff <= new_dst;
         dst_off_ff <= row.dst_offset;
         src_off_ff <= row.src_offset;
         last_ff    <= row.last_row;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_dst_byte = new_dst_ff;
   assign rsp_dst_offset   = dst_off_ff;
   assign rsp_src_offset   = src_off_ff;
   assign rsp_last_row     = last_ff;

endmodule

// ----- rtl/masked_column_raster_op.sv -----
// Top level of the masked column raster block.
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  action, pattern_slot, src_byte, dst_byte
//  rsp      out        rsp_valid / rsp_stall  new_dst_byte, dst_offset, src_offset, last_row
//  csr      in         csr_psel / csr_penable register writes and reads, 32-bit data
//
// One word is accepted per cycle while req_stall is low. An accepted drawn row passes
// through the row register (with the registered pattern store read) and then the result
// register to the result port. Loads, starts and draws past the column give no result.
// Reset is synchronous and clears all control state; req_stall is high during reset.
// A stalled result holds the result register; req_stall rises only when both are full.
`include "assert_macros.svh"
module masked_column_raster_op #(
   parameter int PATTERN_DEPTH = cmr_pkg::PATTERN_DEPTH_DEF,
   parameter int MAX_HEIGHT    = cmr_pkg::MAX_HEIGHT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_action,
   input  logic [3:0]                 req_pattern_slot,
   input  logic [7:0]                 req_src_byte,
   input  logic [7:0]                 req_dst_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_new_dst_byte,
   output logic signed [31:0]         rsp_dst_offset,
   output logic signed [31:0]         rsp_src_offset,
   output logic                       rsp_last_row,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [cmr_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [cmr_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [cmr_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);

   cmr_pkg::cfg_type cfg;
   cmr_pkg::row_type row;
   logic             row_valid;
   logic             row_free;
   logic             out_free;
   logic             req_accept;

   // Flow control: the row register moves on when empty or when the result stage takes it.
   assign row_free   = !row_valid || out_free;
   assign req_stall  = reset || !row_free;
   assign req_accept = req_valid && !req_stall;

   cmr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cmr_row_ctrl #(
      .PATTERN_DEPTH (PATTERN_DEPTH),
      .MAX_HEIGHT    (MAX_HEIGHT)
   ) u_row (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_accept       (req_accept),
      .req_action       (req_action),
      .req_pattern_slot (req_pattern_slot),
      .req_src_byte     (req_src_byte),
      .req_dst_byte     (req_dst_byte),
      .row_load         (row_free),
      .row_valid        (row_valid),
      .row              (row)
   );

   cmr_rop_stage u_rop (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .row_valid        (row_valid),
      .row              (row),
      .rsp_stall        (rsp_stall),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_new_dst_byte (rsp_new_dst_byte),
      .rsp_dst_offset   (rsp_dst_offset),
      .rsp_src_offset   (rsp_src_offset),
      .rsp_last_row     (rsp_last_row)
   );

   // A row enters only with an accepted word.
   `CMR_ASSERT(a_row_from_accept, clock, reset, $rose(row_valid) |-> $past(req_accept))
   // A result appears only from a valid row.
   `CMR_ASSERT(a_rsp_from_row, clock, reset, $rose(rsp_valid) |-> $past(row_valid))
   // Input stalls only when both stages are full and the result is held.
   `CMR_ASSERT(a_stall_full, clock, reset, req_stall |-> row_valid && rsp_valid && rsp_stall)
   // No result is shown in the cycle after reset.
   `CMR_ASSERT_ALWAYS(a_reset_clears, clock, $past(reset) |-> !rsp_valid)

endmodule

// ----- bench/cmr_column_checker.sv -----
// Watches the masked column raster channels, predicts each drawn row and compares results.
`timescale 1ns / 100ps
module cmr_column_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [1:0]                  req_action,
   input  logic [3:0]                  req_pattern_slot,
   input  logic [7:0]                  req_src_byte,
   input  logic [7:0]                  req_dst_byte,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [7:0]                  rsp_new_dst_byte,
   input  logic signed [31:0]          rsp_dst_offset,
   input  logic signed [31:0]          rsp_src_offset,
   input  logic                        rsp_last_row,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [cmr_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [cmr_pkg::CSR_DW-1:0]  csr_pwdata,
   input  logic                        csr_pready,
   output int                          fail_count,
   output int                          rows_pending
);

   localparam logic [10:0] COLUMN_CAP  = 11'(cmr_pkg::MAX_HEIGHT_DEF);
   localparam int          STORE_DEPTH = cmr_pkg::PATTERN_DEPTH_DEF;

   // One drawn row as it should leave the block.
   typedef struct packed {
      logic [7:0]         new_dst_byte;
      logic signed [31:0] dst_offset;
      logic signed [31:0] src_offset;
      logic               last_row;
   } drawn_row_type;

   // Shadow copy of the registers and of the column state.
   cmr_pkg::cfg_type cfg;
   logic [7:0]       pattern_mem [STORE_DEPTH];
   logic [3:0]       pattern_row;
   logic [10:0]      rows_drawn;
   logic [31:0]      dst_acc;
   logic [31:0]      src_acc;
   drawn_row_type    rows_due [$];
   int               errors = 0;

   // Pattern rows actually used before the index wraps.
   function automatic logic [4:0] pattern_span(input logic [4:0] h);
      if (h == 5'd0) begin
         return 5'd1;
      end
      if (h > 5'(STORE_DEPTH)) begin
         return 5'(STORE_DEPTH);
      end
      return h;
   endfunction

   // Masked raster combine of one source byte into one destination byte.
   function automatic logic [7:0] blend(input logic [2:0] mode, input logic [7:0] mask,
                                        input logic [7:0] src, input logic [7:0] dst);
      logic [7:0] masked_src;
      logic [7:0] result;
      masked_src = mask & (src ^ {8{mode[2]}});
      case (mode[1:0])
         cmr_pkg::ROP_COPY: result = masked_src | (dst & ~mask);
         cmr_pkg::ROP_OR:   result = masked_src | dst;
         cmr_pkg::ROP_XOR:  result = masked_src ^ dst;
         default:           result = ~masked_src & dst;
      endcase
      return result;
   endfunction

   // Applies one accepted input word to the shadow state.
   task automatic take_word(input logic [1:0] act, input logic [3:0] slot,
                            input logic [7:0] sbyte, input logic [7:0] dbyte);
      logic [10:0]   col_rows;
      logic [7:0]    src;
      logic [4:0]    next_row;
      drawn_row_type row;
      col_rows = (cfg.column_height > COLUMN_CAP) ? COLUMN_CAP : cfg.column_height;
      case (act)
         cmr_pkg::ACT_LOAD: begin
            pattern_mem[slot] = sbyte;
         end
         cmr_pkg::ACT_START: begin
            rows_drawn  = '0;
            pattern_row = ({1'b0, cfg.start_index} < pattern_span(cfg.pattern_height))
                          ? cfg.start_index : 4'd0;
            dst_acc     = '0;
            src_acc     = '0;
         end
         cmr_pkg::ACT_DRAW: begin
            // Rows past the end of the column leave everything untouched.
            if (rows_drawn < col_rows) begin
               src = cfg.column_mode ? pattern_mem[pattern_row] : sbyte;
               row.new_dst_byte = blend(cfg.transfer_mode, cfg.byte_mask, src, dbyte);
               row.dst_offset   = dst_acc;
               row.src_offset   = cfg.column_mode ? 32'd0 : src_acc;
               row.last_row     = (rows_drawn + 11'd1 == col_rows);
               rows_due.push_back(row);
               rows_drawn = rows_drawn + 11'd1;
               dst_acc = dst_acc + {{16{cfg.dst_row_step[15]}}, cfg.dst_row_step};
               if (cfg.column_mode) begin
                  next_row = {1'b0, pattern_row} + 5'd1;
                  pattern_row = (next_row >= pattern_span(cfg.pattern_height))
                                ? 4'd0 : next_row[3:0];
               end else begin
                  src_acc = src_acc + {{16{cfg.src_row_step[15]}}, cfg.src_row_step};
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   // Mirrors a register write seen on the configuration port.
   task automatic write_register(input logic [2:0] idx, input logic [31:0] v);
      case (cmr_pkg::reg_index_type'(idx))
         cmr_pkg::REG_TRANSFER_MODE:  cfg.transfer_mode  = v[2:0];
         cmr_pkg::REG_BYTE_MASK:      cfg.byte_mask      = v[7:0];
         cmr_pkg::REG_COLUMN_MODE:    cfg.column_mode    = v[0];
         cmr_pkg::REG_PATTERN_HEIGHT: cfg.pattern_height = v[4:0];
         cmr_pkg::REG_START_INDEX:    cfg.start_index    = v[3:0];
         cmr_pkg::REG_DST_ROW_STEP:   cfg.dst_row_step   = v[15:0];
         cmr_pkg::REG_SRC_ROW_STEP:   cfg.src_row_step   = v[15:0];
         cmr_pkg::REG_COLUMN_HEIGHT:  cfg.column_height  = v[10:0];
         default: begin
         end
      endcase
   endtask

   // Results are checked before new words are predicted, so a word accepted
   // at this edge can never match a result leaving at the same edge.
   always @(posedge clock) begin : watch
      drawn_row_type want;
      if (reset) begin
         cfg.transfer_mode  = 3'd0;
         cfg.byte_mask      = 8'hFF;
         cfg.column_mode    = 1'b0;
         cfg.pattern_height = 5'd8;
         cfg.start_index    = 4'd0;
         cfg.dst_row_step   = 16'sd0;
         cfg.src_row_step   = 16'sd0;
         cfg.column_height  = 11'd0;
         pattern_row = '0;
         rows_drawn  = '0;
         dst_acc     = '0;
         src_acc     = '0;
         rows_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rows_due.size() == 0) begin
               errors++;
               $error("result word with no drawn row expected");
            end else begin
               want = rows_due.pop_front();
               if (rsp_new_dst_byte !== want.new_dst_byte) begin
                  errors++;
                  $error("new_dst_byte: expected %02h, got %02h",
                         want.new_dst_byte, rsp_new_dst_byte);
               end
               if (rsp_dst_offset !== want.dst_offset) begin
                  errors++;
                  $error("dst_offset: expected %0d, got %0d", want.dst_offset, rsp_dst_offset);
               end
               if (rsp_src_offset !== want.src_offset) begin
                  errors++;
                  $error("src_offset: expected %0d, got %0d", want.src_offset, rsp_src_offset);
               end
               if (rsp_last_row !== want.last_row) begin
                  errors++;
                  $error("last_row: expected %0b, got %0b", want.last_row, rsp_last_row);
               end
            end
         end
         if (req_valid && !req_stall) begin
            take_word(req_action, req_pattern_slot, req_src_byte, req_dst_byte);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            write_register(csr_paddr[4:2], csr_pwdata);
         end
      end
      rows_pending <= rows_due.size();
      fail_count   <= errors;
   end

endmodule

// ----- bench/testbench.sv -----
// Stimulus and verdict for the masked column raster block.
`timescale 1ns / 100ps
module testbench;

   localparam logic [1:0] ACT_IGNORED = 2'd3;
   localparam int WORD_TARGET = 1500;
   localparam int QUIET_AFTER = 1300;
   localparam int CYCLE_LIMIT = 400000;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [1:0]                 req_action;
   logic [3:0]                 req_pattern_slot;
   logic [7:0]                 req_src_byte;
   logic [7:0]                 req_dst_byte;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [7:0]                 rsp_new_dst_byte;
   logic signed [31:0]         rsp_dst_offset;
   logic signed [31:0]         rsp_src_offset;
   logic                       rsp_last_row;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [cmr_pkg::CSR_AW-1:0] csr_paddr;
   logic [cmr_pkg::CSR_DW-1:0] csr_pwdata;
   logic [cmr_pkg::CSR_DW-1:0] csr_prdata;
   logic                       csr_pready;
   int                         fail_count;
   int                         rows_pending;

   int words_sent  = 0;
   int cycle_count = 0;
   bit idle_on     = 1'b1;

   masked_column_raster_op DUT (.*);

   cmr_column_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Result side: stall bursts between stall-free stretches of random length.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (idle_on && $urandom_range(0, 1) == 1) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Sends one input word, with an occasional gap ahead of it.
   task automatic push_word(input logic [1:0] act, input logic [3:0] slot,
                            input logic [7:0] sbyte, input logic [7:0] dbyte);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_pattern_slot <= slot;
      req_src_byte     <= sbyte;
      req_dst_byte     <= dbyte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (act != ACT_IGNORED) begin
         words_sent++;
      end
      idle_on = (words_sent < QUIET_AFTER);
   endtask

   // Holds off the sender until every drawn row is back and the pipe is empty.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rows_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register write: setup cycle, then access cycle.
   task automatic csr_write(input cmr_pkg::reg_index_type idx, input logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_row_step();
      case ($urandom_range(0, 4))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'($urandom_range(0, 8)) - 16'd4;
         default: return 16'($urandom);
      endcase
   endfunction

   // Programs a fresh column setting and returns how many words to send.
   task automatic configure_column(input bit tall, output int rows);
      int height;
      case ($urandom_range(0, 19))
         0, 1:    height = 0;
         2:       height = $urandom_range(1025, 2047);
         3:       height = 1024;
         default: height = $urandom_range(1, 24);
      endcase
      if (tall) begin
         height = 2047;
      end
      csr_write(cmr_pkg::REG_TRANSFER_MODE, 32'($urandom_range(0, 7)));
      case ($urandom_range(0, 3))
         0:       csr_write(cmr_pkg::REG_BYTE_MASK, 32'h00);
         1:       csr_write(cmr_pkg::REG_BYTE_MASK, 32'hFF);
         default: csr_write(cmr_pkg::REG_BYTE_MASK, 32'($urandom_range(0, 255)));
      endcase
      csr_write(cmr_pkg::REG_COLUMN_MODE, 32'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) begin
         csr_write(cmr_pkg::REG_PATTERN_HEIGHT, 32'($urandom_range(0, 31)));
      end else begin
         csr_write(cmr_pkg::REG_PATTERN_HEIGHT, 32'($urandom_range(1, 16)));
      end
      csr_write(cmr_pkg::REG_START_INDEX, 32'($urandom_range(0, 15)));
      csr_write(cmr_pkg::REG_DST_ROW_STEP, 32'(pick_row_step()));
      csr_write(cmr_pkg::REG_SRC_ROW_STEP, 32'(pick_row_step()));
      csr_write(cmr_pkg::REG_COLUMN_HEIGHT, 32'(height));
      // Tall columns are only walked to the end once; otherwise a few rows suffice.
      if (tall) begin
         rows = 1026;
      end else if (height > 40) begin
         rows = $urandom_range(5, 30);
      end else begin
         rows = height + $urandom_range(0, 3);
      end
   endtask

   // One column: mostly draws, with loads, restarts and ignored words mixed in.
   task automatic run_column(input bit tall);
      int rows;
      int pick;
      wait_idle();
      configure_column(tall, rows);
      if (tall || $urandom_range(0, 4) != 0) begin
         push_word(cmr_pkg::ACT_START, 4'($urandom), 8'($urandom), 8'($urandom));
      end
      for (int k = 0; k < rows; k++) begin
         pick = $urandom_range(0, 99);
         if (tall || pick < 82) begin
            push_word(cmr_pkg::ACT_DRAW, 4'($urandom), 8'($urandom), 8'($urandom));
         end else if (pick < 91) begin
            push_word(cmr_pkg::ACT_LOAD, 4'($urandom), 8'($urandom), 8'($urandom));
         end else if (pick < 95) begin
            push_word(cmr_pkg::ACT_START, 4'($urandom), 8'($urandom), 8'($urandom));
         end else begin
            push_word(ACT_IGNORED, 4'($urandom), 8'($urandom), 8'($urandom));
         end
      end
   endtask

   initial begin
      int phase;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = cmr_pkg::ACT_LOAD;
      req_pattern_slot = '0;
      req_src_byte     = '0;
      req_dst_byte     = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset setting has an empty column, so this draw gives nothing.
      push_word(cmr_pkg::ACT_DRAW, 4'd0, 8'hFF, 8'hFF);
      push_word(ACT_IGNORED, 4'hF, 8'hFF, 8'h00);
      // Fill the whole pattern store before any pattern-mode draw can read it.
      for (int i = 0; i < cmr_pkg::PATTERN_DEPTH_DEF; i++) begin
         push_word(cmr_pkg::ACT_LOAD, 4'(i),
                   (i == 0) ? 8'h00 : (i == 15) ? 8'hFF : 8'($urandom), 8'($urandom));
      end

      // Inverted bit-clear, odd mask, extreme row steps, short blit column.
      wait_idle();
      csr_write(cmr_pkg::REG_TRANSFER_MODE, 32'd7);
      csr_write(cmr_pkg::REG_BYTE_MASK, 32'h5A);
      csr_write(cmr_pkg::REG_COLUMN_MODE, 32'd0);
      csr_write(cmr_pkg::REG_DST_ROW_STEP, 32'h8000);
      csr_write(cmr_pkg::REG_SRC_ROW_STEP, 32'h7FFF);
      csr_write(cmr_pkg::REG_COLUMN_HEIGHT, 32'd4);
      // A draw before any start runs from the reset row state.
      push_word(cmr_pkg::ACT_DRAW, 4'd0, 8'hFF, 8'h00);
      push_word(cmr_pkg::ACT_START, 4'd0, 8'h00, 8'h00);
      push_word(cmr_pkg::ACT_DRAW, 4'd0, 8'h00, 8'hFF);
      push_word(cmr_pkg::ACT_DRAW, 4'd0, 8'hFF, 8'hFF);
      push_word(cmr_pkg::ACT_DRAW, 4'd0, 8'h55, 8'hAA);
      push_word(cmr_pkg::ACT_DRAW, 4'd0, 8'hAA, 8'h55);
      // Past the end of the column.
      push_word(cmr_pkg::ACT_DRAW, 4'd0, 8'hFF, 8'h00);

      phase = 0;
      while (words_sent < WORD_TARGET) begin
         run_column(phase == 3);
         phase++;
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/cmr_pkg.sv
rtl/cmr_csr.sv
rtl/cmr_row_ctrl.sv
rtl/cmr_rop_stage.sv
rtl/masked_column_raster_op.sv
bench/cmr_column_checker.sv
bench/testbench.sv
